// ===== rtl/fpp_pkg.sv =====
// ----------------------------------------------------------------------------
// fpp_pkg: shared types, constants and functions of the framed packet parser
// Holds the phase encoding, status and error codes, register indexes, the
// queue entry and result formats and the byte-wide crc-16 update.
// ----------------------------------------------------------------------------
package fpp_pkg;

  // largest payload the parser handles, in bytes
  localparam int unsigned MaxPayload = 256;
  // byte counter width, wide enough to hold MaxPayload itself
  localparam int unsigned CountW     = $clog2(MaxPayload + 1);

  // configuration port
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 9;
  localparam int unsigned MaxLenW    = 9;

  // decoupling queue between front and back
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QAddrW     = $clog2(QDepth);

  // reset values
  localparam logic [7:0]         SofFirstRst = 8'hAA;
  localparam logic [7:0]         SofSecondRst = 8'h55;
  localparam logic [7:0]         VersionRst  = 8'h01;
  localparam logic [MaxLenW-1:0] MaxLenRst   = 9'd256;

  // crc-16/ccitt-false
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOF_FIRST  = 2'd0,
    CFG_SOF_SECOND = 2'd1,
    CFG_VERSION    = 2'd2,
    CFG_MAX_LEN    = 2'd3
  } cfg_idx_e;

  // parser phases
  typedef enum logic [3:0] {
    PH_SOF_A   = 4'd0,
    PH_SOF_B   = 4'd1,
    PH_VER     = 4'd2,
    PH_SEQ     = 4'd3,
    PH_TYPE    = 4'd4,
    PH_DEV     = 4'd5,
    PH_CMD     = 4'd6,
    PH_LEN_LO  = 4'd7,
    PH_LEN_HI  = 4'd8,
    PH_DATA    = 4'd9,
    PH_CRC_LO  = 4'd10,
    PH_CRC_HI  = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_READY = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_VERSION = 2'd1,
    ERR_LENGTH  = 2'd2,
    ERR_CRC     = 2'd3
  } error_e;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_second;
    logic       is_version;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         error_code;
    logic               payload_valid;
    logic [7:0]         payload_byte;
    logic [7:0]         payload_index;
    logic [7:0]         seq_number;
    logic [7:0]         message_type;
    logic [7:0]         device_number;
    logic [7:0]         command_number;
    logic [MaxLenW-1:0] frame_payload_len;
  } result_t;

  // one byte through the msb-first crc register
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/fpp_front.sv =====
// ----------------------------------------------------------------------------
// fpp_front: input side of the framed packet parser
// Holds the configuration registers, takes received bytes and tags each one
// with its start-marker and version matches before it enters the queue.
// ----------------------------------------------------------------------------
module fpp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fpp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         q_push_o,
  output fpp_pkg::item_t               q_item_o,
  input  logic                         q_ready_i,
  output logic [fpp_pkg::MaxLenW-1:0]  max_len_o
);

  logic [7:0]                  sof_first_q;
  logic [7:0]                  sof_second_q;
  logic [7:0]                  version_q;
  logic [fpp_pkg::MaxLenW-1:0] max_len_q;

  // configuration registers, out-of-range writes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_first_q  <= fpp_pkg::SofFirstRst;
      sof_second_q <= fpp_pkg::SofSecondRst;
      version_q    <= fpp_pkg::VersionRst;
      max_len_q    <= fpp_pkg::MaxLenRst;
    end else if (cfg_we_i) begin
      case (fpp_pkg::cfg_idx_e'(cfg_index_i))
        fpp_pkg::CFG_SOF_FIRST:  sof_first_q  <= cfg_data_i[7:0];
        fpp_pkg::CFG_SOF_SECOND: sof_second_q <= cfg_data_i[7:0];
        fpp_pkg::CFG_VERSION:    version_q    <= cfg_data_i[7:0];
        fpp_pkg::CFG_MAX_LEN:    max_len_q    <= cfg_data_i[fpp_pkg::MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  // classify the incoming byte
  always_comb begin
    q_item_o.data       = rx_byte_i;
    q_item_o.is_first   = (rx_byte_i == sof_first_q);
    q_item_o.is_second  = (rx_byte_i == sof_second_q);
    q_item_o.is_version = (rx_byte_i == version_q);
  end

  // handshake into the queue
  assign q_push_o   = in_valid_i && q_ready_i;
  assign in_stall_o = !q_ready_i;
  assign max_len_o  = max_len_q;

endmodule

// ===== rtl/fpp_queue.sv =====
// ----------------------------------------------------------------------------
// fpp_queue: short fifo between front and back
// Lets the input side keep taking bytes while the result side is stalled.
// ----------------------------------------------------------------------------
module fpp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpp_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fpp_pkg::item_t item_o
);

  fpp_pkg::item_t                mem_q [fpp_pkg::QDepth];
  logic [fpp_pkg::QAddrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [fpp_pkg::QAddrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [fpp_pkg::QAddrW:0]      count_q, count_d;

  assign ready_o = (count_q != (fpp_pkg::QAddrW+1)'(fpp_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/fpp_back.sv =====
// ----------------------------------------------------------------------------
// fpp_back: frame parsing state machine and result register
// Steps the frame phase once per queued byte, keeps header fields and the
// running crc, and holds each result until the consumer takes it.
// ----------------------------------------------------------------------------
module fpp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  fpp_pkg::item_t              q_item_i,
  output logic                        q_pop_o,
  input  logic [fpp_pkg::MaxLenW-1:0] max_len_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fpp_pkg::result_t            res_o
);

  fpp_pkg::phase_e              phase_q, phase_d;
  logic [7:0]                   hdr_seq_q, hdr_seq_d;
  logic [7:0]                   hdr_type_q, hdr_type_d;
  logic [7:0]                   hdr_dev_q, hdr_dev_d;
  logic [7:0]                   hdr_cmd_q, hdr_cmd_d;
  logic [15:0]                  len_q, len_d;
  logic [fpp_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic [7:0]                   crc_lo_q, crc_lo_d;
  logic [15:0]                  crc_q, crc_d;
  logic                         out_valid_q;
  fpp_pkg::result_t             res_q, res_d;

  logic [7:0]                   b;
  logic [15:0]                  crc_next;
  logic [15:0]                  len_full;
  logic [15:0]                  limit;
  logic [fpp_pkg::CountW-1:0]   cnt_inc;
  logic                         len_bad;
  logic                         data_last;
  logic                         crc_good;

  // take a byte whenever the result register is free or being emptied
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign b         = q_item_i.data;
  assign crc_next  = fpp_pkg::crc_feed(crc_q, b);
  assign len_full  = {b, len_q[7:0]};
  assign limit     = ({{(16-fpp_pkg::MaxLenW){1'b0}}, max_len_i} > 16'(fpp_pkg::MaxPayload))
                     ? 16'(fpp_pkg::MaxPayload)
                     : {{(16-fpp_pkg::MaxLenW){1'b0}}, max_len_i};
  assign len_bad   = (len_full > limit);
  assign cnt_inc   = cnt_q + 1'b1;
  assign data_last = (16'(cnt_inc) >= len_q);
  assign crc_good  = ({b, crc_lo_q} == crc_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      fpp_pkg::PH_SOF_A: begin
        if (q_item_i.is_first) phase_d = fpp_pkg::PH_SOF_B;
      end
      fpp_pkg::PH_SOF_B: begin
        if (q_item_i.is_second) begin
          phase_d = fpp_pkg::PH_VER;
        end else if (!q_item_i.is_first) begin
          phase_d = fpp_pkg::PH_SOF_A;
        end
      end
      fpp_pkg::PH_VER: begin
        phase_d = q_item_i.is_version ? fpp_pkg::PH_SEQ : fpp_pkg::PH_SOF_A;
      end
      fpp_pkg::PH_SEQ:    phase_d = fpp_pkg::PH_TYPE;
      fpp_pkg::PH_TYPE:   phase_d = fpp_pkg::PH_DEV;
      fpp_pkg::PH_DEV:    phase_d = fpp_pkg::PH_CMD;
      fpp_pkg::PH_CMD:    phase_d = fpp_pkg::PH_LEN_LO;
      fpp_pkg::PH_LEN_LO: phase_d = fpp_pkg::PH_LEN_HI;
      fpp_pkg::PH_LEN_HI: begin
        if (len_bad) begin
          phase_d = fpp_pkg::PH_SOF_A;
        end else if (len_full == 16'd0) begin
          phase_d = fpp_pkg::PH_CRC_LO;
        end else begin
          phase_d = fpp_pkg::PH_DATA;
        end
      end
      fpp_pkg::PH_DATA: begin
        if (data_last) phase_d = fpp_pkg::PH_CRC_LO;
      end
      fpp_pkg::PH_CRC_LO: phase_d = fpp_pkg::PH_CRC_HI;
      fpp_pkg::PH_CRC_HI: phase_d = fpp_pkg::PH_SOF_A;
      default:            phase_d = fpp_pkg::PH_SOF_A;
    endcase
  end

  // datapath updates and the result of this byte
  always_comb begin
    hdr_seq_d  = hdr_seq_q;
    hdr_type_d = hdr_type_q;
    hdr_dev_d  = hdr_dev_q;
    hdr_cmd_d  = hdr_cmd_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    crc_lo_d   = crc_lo_q;
    crc_d      = crc_q;
    res_d      = '0;
    res_d.status     = fpp_pkg::ST_BUSY;
    res_d.error_code = fpp_pkg::ERR_NONE;
    case (phase_q)
      fpp_pkg::PH_SOF_A: ;
      fpp_pkg::PH_SOF_B: begin
        if (q_item_i.is_second) begin
          hdr_seq_d  = '0;
          hdr_type_d = '0;
          hdr_dev_d  = '0;
          hdr_cmd_d  = '0;
          crc_d      = fpp_pkg::CrcInit;
        end
      end
      fpp_pkg::PH_VER: begin
        if (q_item_i.is_version) begin
          crc_d = crc_next;
        end else begin
          len_d    = '0;
          cnt_d    = '0;
          crc_lo_d = '0;
          res_d.status         = fpp_pkg::ST_ERROR;
          res_d.error_code     = fpp_pkg::ERR_VERSION;
          res_d.seq_number     = hdr_seq_q;
          res_d.message_type   = hdr_type_q;
          res_d.device_number  = hdr_dev_q;
          res_d.command_number = hdr_cmd_q;
        end
      end
      fpp_pkg::PH_SEQ: begin
        hdr_seq_d = b;
        crc_d     = crc_next;
      end
      fpp_pkg::PH_TYPE: begin
        hdr_type_d = b;
        crc_d      = crc_next;
      end
      fpp_pkg::PH_DEV: begin
        hdr_dev_d = b;
        crc_d     = crc_next;
      end
      fpp_pkg::PH_CMD: begin
        hdr_cmd_d = b;
        crc_d     = crc_next;
      end
      fpp_pkg::PH_LEN_LO: begin
        len_d = {8'h00, b};
        crc_d = crc_next;
      end
      fpp_pkg::PH_LEN_HI: begin
        crc_d = crc_next;
        cnt_d = '0;
        if (len_bad) begin
          len_d    = '0;
          crc_lo_d = '0;
          res_d.status         = fpp_pkg::ST_ERROR;
          res_d.error_code     = fpp_pkg::ERR_LENGTH;
          res_d.seq_number     = hdr_seq_q;
          res_d.message_type   = hdr_type_q;
          res_d.device_number  = hdr_dev_q;
          res_d.command_number = hdr_cmd_q;
        end else begin
          len_d = len_full;
        end
      end
      fpp_pkg::PH_DATA: begin
        res_d.payload_valid = 1'b1;
        res_d.payload_byte  = b;
        res_d.payload_index = 8'(cnt_q);
        crc_d = crc_next;
        cnt_d = cnt_inc;
      end
      fpp_pkg::PH_CRC_LO: begin
        crc_lo_d = b;
      end
      fpp_pkg::PH_CRC_HI: begin
        len_d    = '0;
        cnt_d    = '0;
        crc_lo_d = '0;
        res_d.seq_number     = hdr_seq_q;
        res_d.message_type   = hdr_type_q;
        res_d.device_number  = hdr_dev_q;
        res_d.command_number = hdr_cmd_q;
        if (crc_good) begin
          res_d.status            = fpp_pkg::ST_READY;
          res_d.frame_payload_len = len_q[fpp_pkg::MaxLenW-1:0];
        end else begin
          res_d.status     = fpp_pkg::ST_ERROR;
          res_d.error_code = fpp_pkg::ERR_CRC;
        end
      end
      default: begin
        len_d    = '0;
        cnt_d    = '0;
        crc_lo_d = '0;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= fpp_pkg::PH_SOF_A;
      hdr_seq_q  <= '0;
      hdr_type_q <= '0;
      hdr_dev_q  <= '0;
      hdr_cmd_q  <= '0;
      len_q      <= '0;
      cnt_q      <= '0;
      crc_lo_q   <= '0;
      crc_q      <= fpp_pkg::CrcInit;
    end else if (q_pop_o) begin
      phase_q    <= phase_d;
      hdr_seq_q  <= hdr_seq_d;
      hdr_type_q <= hdr_type_d;
      hdr_dev_q  <= hdr_dev_d;
      hdr_cmd_q  <= hdr_cmd_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      crc_lo_q   <= crc_lo_d;
      crc_q      <= crc_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/framed_packet_parser_crc16_core.sv =====
// ----------------------------------------------------------------------------
// framed_packet_parser_crc16_core: framed packet parser with crc-16 check
// Path: a byte accepted into the queue is popped once the result register is
//   free or being emptied, and its result transaction is then offered from
//   the result register until the consumer takes it.
// Throughput: one byte per cycle while out_stall_i is low, set by the byte-wide
//   crc update and phase step in the back end; a four-entry queue absorbs stalls.
// Reset: asynchronous, active low; registers return to their defaults, the
//   parser hunts for the first start byte and the queue is empty.
// ----------------------------------------------------------------------------
module framed_packet_parser_crc16_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [fpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fpp_pkg::CfgDataW-1:0] cfg_data_i,
  // received bytes
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [1:0]                   error_code_o,
  output logic                         payload_valid_o,
  output logic [7:0]                   payload_byte_o,
  output logic [7:0]                   payload_index_o,
  output logic [7:0]                   seq_number_o,
  output logic [7:0]                   message_type_o,
  output logic [7:0]                   device_number_o,
  output logic [7:0]                   command_number_o,
  output logic [fpp_pkg::MaxLenW-1:0]  frame_payload_len_o
);

  logic                        q_push;
  logic                        q_ready;
  logic                        q_pop;
  logic                        q_valid;
  fpp_pkg::item_t              q_item_in;
  fpp_pkg::item_t              q_item_out;
  logic [fpp_pkg::MaxLenW-1:0] max_len;
  fpp_pkg::result_t            res;

  // byte intake and classification
  fpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .q_push_o    (q_push),
    .q_item_o    (q_item_in),
    .q_ready_i   (q_ready),
    .max_len_o   (max_len)
  );

  // decoupling queue
  fpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item_out)
  );

  // frame parsing
  fpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item_out),
    .q_pop_o     (q_pop),
    .max_len_i   (max_len),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // result fields
  assign status_o            = res.status;
  assign error_code_o        = res.error_code;
  assign payload_valid_o     = res.payload_valid;
  assign payload_byte_o      = res.payload_byte;
  assign payload_index_o     = res.payload_index;
  assign seq_number_o        = res.seq_number;
  assign message_type_o      = res.message_type;
  assign device_number_o     = res.device_number;
  assign command_number_o    = res.command_number;
  assign frame_payload_len_o = res.frame_payload_len;

endmodule
